### hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

   // field widths of the stream payloads
   localparam int unsigned CMD_W       = 1;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned TOP_W       = 32;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned ERR_W       = 2;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 40;

   // operation codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

   // result error codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

   // operation broadcast to every cell of the chain
   typedef struct packed {
      logic insert_en;
      logic remove_en;
      logic smallest_first;
   } cell_op_type;

endpackage

`default_nettype wire

### hdl/sorted_priority_queue_unit.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// Request stream (req_*): one item per transfer, cmd 0 inserts value at its
// ordered place, cmd 1 removes the top entry. Response stream (rsp_*): exactly
// one response per request with the top value, entry count, empty flag and
// error code as they stand after the operation.
// Every cell compares the incoming value against its entry at once and a
// single ripple of "found" through the row picks the insert slot, so an
// operation finishes in the cycle it is accepted: the response is valid on the
// next cycle, and one request per cycle is taken as long as rsp_tready is high.
// An insert into a full queue or a remove from an empty one leaves the entries
// untouched and reports the error code.
// When the receiver stalls, the response holds and req_tready drops until the
// response transfer completes.
// Reset (synchronous) empties the queue and selects largest-first ordering.
// csr_wr_en/csr_wr_data write the ordering bit (1 = smallest first); write it
// only while no response is outstanding. Entries already stored keep their
// places after an ordering change.
`default_nettype none

module sorted_priority_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [0] cmd, [32:1] value, [39:33] zero
   input  wire  [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [31:0] top_value, [36:32] count, [37] is_empty, [39:38] error_code
   output logic [39:0] rsp_tdata,
   input  wire         csr_wr_en,
   input  wire         csr_wr_data
);

   localparam int unsigned StoreW  = (VALUE_WIDTH < spq_pkg::VALUE_W) ?
                                     VALUE_WIDTH : spq_pkg::VALUE_W;
   localparam int unsigned CountW  = $clog2(QUEUE_DEPTH + 1);

   logic                           order_ff;
   logic [CountW-1:0]              count_ff, count_in;
   logic                           rsp_valid_ff;
   logic [spq_pkg::ERR_W-1:0]      err_ff, err_in;

   logic                           accept;
   logic [spq_pkg::CMD_W-1:0]      cmd;
   logic [StoreW-1:0]              ins_value;
   logic                           is_full;
   logic                           is_empty_now;
   spq_pkg::cell_op_type           op;

   logic [QUEUE_DEPTH-1:0][StoreW-1:0] cell_data;
   logic [QUEUE_DEPTH-1:0]             cell_occ;
   logic [QUEUE_DEPTH-1:0]             cell_found;

   logic [31:0]                    count_wide;
   logic [spq_pkg::TOP_W-1:0]      top_value;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign cmd          = req_tdata[0];
   assign ins_value    = req_tdata[StoreW:1];
   assign is_full      = count_ff == CountW'(QUEUE_DEPTH);
   assign is_empty_now = count_ff == '0;

   always_comb begin
      op.insert_en      = 1'b0;
      op.remove_en      = 1'b0;
      op.smallest_first = order_ff;
      count_in          = count_ff;
      err_in            = err_ff;
      if (accept) begin
         err_in = spq_pkg::ERR_OK;
         if (cmd == spq_pkg::CMD_INSERT) begin
            if (is_full) begin
               err_in = spq_pkg::ERR_FULL;
            end else begin
               op.insert_en = 1'b1;
               count_in     = count_ff + CountW'(1);
            end
         end else begin
            if (is_empty_now) begin
               err_in = spq_pkg::ERR_EMPTY;
            end else begin
               op.remove_en = 1'b1;
               count_in     = count_ff - CountW'(1);
            end
         end
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic              found_in;
      logic [StoreW-1:0] prev_data;
      logic              prev_occ;
      logic [StoreW-1:0] next_data;
      logic              next_occ;

      if (i == 0) begin : g_head
         assign found_in  = 1'b0;
         assign prev_data = ins_value;
         assign prev_occ  = 1'b0;
      end else begin : g_body
         assign found_in  = cell_found[i-1];
         assign prev_data = cell_data[i-1];
         assign prev_occ  = cell_occ[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_data = cell_data[i];
         assign next_occ  = 1'b0;
      end else begin : g_mid
         assign next_data = cell_data[i+1];
         assign next_occ  = cell_occ[i+1];
      end

      spq_cell #(
         .DATA_W (StoreW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .ins_value (ins_value),
         .found_in  (found_in),
         .prev_data (prev_data),
         .prev_occ  (prev_occ),
         .next_data (next_data),
         .next_occ  (next_occ),
         .found_out (cell_found[i]),
         .data      (cell_data[i]),
         .occ       (cell_occ[i])
      );
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      if (reset) begin
         order_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // head cell holds the top entry; cells stay still while a response waits
   always_comb begin
      top_value = '0;
      if (cell_occ[0]) begin
         top_value[StoreW-1:0] = cell_data[0];
      end
   end

   assign count_wide = 32'(count_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {err_ff, is_empty_now, count_wide[spq_pkg::COUNT_W-1:0], top_value};

endmodule

`default_nettype wire

### hdl/spq_cell.sv
`default_nettype none

module spq_cell #(
   parameter int unsigned DATA_W = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire spq_pkg::cell_op_type op,
   input  wire [DATA_W-1:0]         ins_value,
   // left neighbor (higher priority side)
   input  wire                      found_in,
   input  wire [DATA_W-1:0]         prev_data,
   input  wire                      prev_occ,
   // right neighbor (lower priority side)
   input  wire [DATA_W-1:0]         next_data,
   input  wire                      next_occ,
   output logic                     found_out,
   output logic [DATA_W-1:0]        data,
   output logic                     occ
);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              occ_ff, occ_in;
   logic              outranks;
   logic              hit;

   always_comb begin
      if (op.smallest_first) begin
         outranks = ins_value < data_ff;
      end else begin
         outranks = ins_value > data_ff;
      end
   end

   // first cell that is free or holds a strictly lower priority takes the new value
   assign hit       = !occ_ff || outranks;
   assign found_out = found_in || hit;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      if (op.insert_en) begin
         if (found_in) begin
            data_in = prev_data;
            occ_in  = prev_occ;
         end else if (hit) begin
            data_in = ins_value;
            occ_in  = 1'b1;
         end
      end else if (op.remove_en) begin
         data_in = next_data;
         occ_in  = next_occ;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign data = data_ff;
   assign occ  = occ_ff;

endmodule

`default_nettype wire
